>>> rtl/sgtc_pkg.sv
// shared types and constants for the speech gate and tone chain
package sgtc_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_GATE_ENABLE = 3'd0;
  localparam logic [2:0] REG_TREBLE_LEVEL = 3'd1;
  localparam logic [2:0] REG_BASS_LEVEL = 3'd2;
  localparam logic [2:0] REG_GATE_OPEN = 3'd3;
  localparam logic [2:0] REG_GATE_CLOSE = 3'd4;

  // register reset values
  localparam logic [14:0] GATE_OPEN_RST = 15'd2000;
  localparam logic [14:0] GATE_CLOSE_RST = 15'd800;

  // shared multiplier operand widths
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // sequencer step counter width
  localparam int unsigned STEP_W = 5;

  // operand a select
  typedef enum logic [3:0] {
    A_M,
    A_MAG,
    A_G,
    A_X,
    A_XS,
    A_XH0,
    A_XH1,
    A_YH0,
    A_YH1
  } a_sel_t;

  // operand b select
  typedef enum logic [3:0] {
    B_KM,
    B_KMAG,
    B_KG,
    B_GAIN,
    B_C0,
    B_C1,
    B_C2,
    B_C3,
    B_C4
  } b_sel_t;

  // datapath action on the previous step's product
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD_SH16,
    ACT_ADD,
    ACT_GATE_UPD,
    ACT_GATE_DEC,
    ACT_X_GATE,
    ACT_LOAD_RES,
    ACT_SUB,
    ACT_FILT_DONE
  } act_t;

  // sequencing of the step counter
  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_NOGATE,
    JMP_END
  } jmp_t;

  // one control word
  typedef struct packed {
    a_sel_t              a_sel;
    b_sel_t              b_sel;
    act_t                act;
    logic                filt;    // 0 bass, 1 treble
    jmp_t                jmp;
    logic [STEP_W-1:0]   target;
  } ctrl_t;

  // sequencer status toward the rest of the block
  typedef struct packed {
    logic busy;
    logic exec;
    logic fin;
  } seq_stat_t;

  // configuration register set
  typedef struct packed {
    logic        gate_en;
    logic [3:0]  treb_lvl;
    logic [3:0]  bass_lvl;
    logic [14:0] open_lvl;
    logic [14:0] close_lvl;
  } cfg_t;

  // per-filter history
  typedef struct packed {
    logic signed [15:0] xh0;
    logic signed [15:0] xh1;
    logic signed [15:0] yh0;
    logic signed [15:0] yh1;
    logic [13:0]        res;
  } hist_t;

endpackage

>>> rtl/sgtc_mul.sv
// shared signed multiplier with registered product
module sgtc_mul import sgtc_pkg::*; (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [MUL_A_W-1:0]   a,
  input  logic signed [MUL_B_W-1:0]   b,
  output logic signed [MUL_P_W-1:0]   p
);

  logic signed [MUL_P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= MUL_P_W'(a) * MUL_P_W'(b);
    end
  end

  assign p = p_r;

endmodule

>>> rtl/sgtc_useq.sv
// microcode sequencer: step counter, control store and jumps
module sgtc_useq import sgtc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      gate_en,
  input  logic      out_blocked,
  output ctrl_t     ctrl,
  output seq_stat_t stat
);

  localparam logic [STEP_W-1:0] STEP_BASS = 5'd6;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] pc);
    ctrl_t w;
    case (pc)
      // gate: smoothed magnitude, gain ramp, decision, scaling
      5'd0:  w = '{A_M,   B_KM,   ACT_NONE,      1'b0, JMP_NOGATE, STEP_BASS};
      5'd1:  w = '{A_MAG, B_KMAG, ACT_LOAD_SH16, 1'b0, JMP_NEXT,   5'd0};
      5'd2:  w = '{A_G,   B_KG,   ACT_ADD,       1'b0, JMP_NEXT,   5'd0};
      5'd3:  w = '{A_X,   B_KM,   ACT_GATE_UPD,  1'b0, JMP_NEXT,   5'd0};
      5'd4:  w = '{A_X,   B_GAIN, ACT_GATE_DEC,  1'b0, JMP_NEXT,   5'd0};
      5'd5:  w = '{A_X,   B_KM,   ACT_X_GATE,    1'b0, JMP_NEXT,   5'd0};
      // bass shelf
      5'd6:  w = '{A_XS,  B_C0,   ACT_NONE,      1'b0, JMP_NEXT,   5'd0};
      5'd7:  w = '{A_XH0, B_C1,   ACT_LOAD_RES,  1'b0, JMP_NEXT,   5'd0};
      5'd8:  w = '{A_XH1, B_C2,   ACT_ADD,       1'b0, JMP_NEXT,   5'd0};
      5'd9:  w = '{A_YH0, B_C3,   ACT_ADD,       1'b0, JMP_NEXT,   5'd0};
      5'd10: w = '{A_YH1, B_C4,   ACT_SUB,       1'b0, JMP_NEXT,   5'd0};
      5'd11: w = '{A_X,   B_KM,   ACT_FILT_DONE, 1'b0, JMP_NEXT,   5'd0};
      // treble shelf
      5'd12: w = '{A_XS,  B_C0,   ACT_NONE,      1'b1, JMP_NEXT,   5'd0};
      5'd13: w = '{A_XH0, B_C1,   ACT_LOAD_RES,  1'b1, JMP_NEXT,   5'd0};
      5'd14: w = '{A_XH1, B_C2,   ACT_ADD,       1'b1, JMP_NEXT,   5'd0};
      5'd15: w = '{A_YH0, B_C3,   ACT_ADD,       1'b1, JMP_NEXT,   5'd0};
      5'd16: w = '{A_YH1, B_C4,   ACT_SUB,       1'b1, JMP_NEXT,   5'd0};
      5'd17: w = '{A_X,   B_KM,   ACT_FILT_DONE, 1'b1, JMP_END,    5'd0};
      default: w = '{A_M, B_KM,   ACT_NONE,      1'b0, JMP_END,    5'd0};
    endcase
    return w;
  endfunction

  logic [STEP_W-1:0] pc_r;
  logic [STEP_W-1:0] pc_nxt;
  logic              busy_r;
  logic              busy_nxt;
  logic              stall;
  logic              exec;

  always_comb begin
    ctrl  = ucode(pc_r);
    // last step waits until the result register is free
    stall = (ctrl.jmp == JMP_END) && out_blocked;
    exec  = busy_r && !stall;
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (start) begin
      pc_nxt   = '0;
      busy_nxt = 1'b1;
    end else if (exec) begin
      case (ctrl.jmp)
        JMP_NEXT:   pc_nxt = pc_r + 1'b1;
        JMP_NOGATE: pc_nxt = gate_en ? pc_r + 1'b1 : ctrl.target;
        JMP_END: begin
          pc_nxt   = '0;
          busy_nxt = 1'b0;
        end
        default:    pc_nxt = pc_r + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.exec = exec;
  assign stat.fin  = exec && (ctrl.jmp == JMP_END);

endmodule

>>> rtl/sgtc_dp.sv
// datapath: gate and shelf state, operand select, accumulator
module sgtc_dp import sgtc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic signed [15:0]         x_in,
  input  logic                       exec,
  input  ctrl_t                      ctrl,
  input  cfg_t                       cfg,
  input  logic signed [MUL_P_W-1:0]  prod,
  output logic signed [MUL_A_W-1:0]  mul_a,
  output logic signed [MUL_B_W-1:0]  mul_b,
  output logic signed [15:0]         y_out
);

  localparam logic [MUL_B_W-1:0] K_M_DECAY    = 18'd58982;
  localparam logic [MUL_B_W-1:0] K_M_ATTACK   = 18'd6554;
  localparam logic [MUL_B_W-1:0] K_G_OPEN     = 18'd62259;
  localparam logic [MUL_B_W-1:0] K_G_CLOSED   = 18'd64881;
  localparam logic [17:0]        G_STEP       = 18'd3277;
  localparam logic [17:0]        G_UNITY      = 18'd65536;
  localparam logic signed [39:0] ACC_HI       = 40'sd268435455;
  localparam logic signed [39:0] ACC_LO       = -40'sd268435456;

  // b0, b1, b2, a1, a2 per level
  localparam logic signed [17:0] BASS_COEF [0:10][0:4] = '{
    '{18'sd12775, -18'sd17118, 18'sd6504, -18'sd14782, 18'sd5232},
    '{18'sd13435, -18'sd17518, 18'sd6584, -18'sd15628, 18'sd5526},
    '{18'sd14123, -18'sd17884, 18'sd6650, -18'sd16446, 18'sd5827},
    '{18'sd14842, -18'sd18210, 18'sd6702, -18'sd17235, 18'sd6135},
    '{18'sd15594, -18'sd18492, 18'sd6739, -18'sd17995, 18'sd6448},
    '{18'sd16383, -18'sd18725, 18'sd6763, -18'sd18725, 18'sd6763},
    '{18'sd17212, -18'sd18905, 18'sd6774, -18'sd19427, 18'sd7080},
    '{18'sd18084, -18'sd19025, 18'sd6772, -18'sd20101, 18'sd7398},
    '{18'sd19005, -18'sd19078, 18'sd6760, -18'sd20746, 18'sd7714},
    '{18'sd19979, -18'sd19058, 18'sd6739, -18'sd21363, 18'sd8029},
    '{18'sd21010, -18'sd18957, 18'sd6710, -18'sd21953, 18'sd8341}
  };
  localparam logic signed [17:0] TREB_COEF [0:10][0:4] = '{
    '{18'sd6958,  -18'sd4956,  18'sd1828,  -18'sd19812, 18'sd7260},
    '{18'sd8253,  -18'sd6351,  18'sd2297,  -18'sd19127, 18'sd6942},
    '{18'sd9793,  -18'sd8081,  18'sd2885,  -18'sd18412, 18'sd6626},
    '{18'sd11623, -18'sd10221, 18'sd3623,  -18'sd17669, 18'sd6312},
    '{18'sd13799, -18'sd12857, 18'sd4546,  -18'sd16896, 18'sd6001},
    '{18'sd16383, -18'sd16095, 18'sd5696,  -18'sd16095, 18'sd5696},
    '{18'sd19451, -18'sd20061, 18'sd7125,  -18'sd15265, 18'sd5397},
    '{18'sd23092, -18'sd24904, 18'sd8896,  -18'sd14406, 18'sd5107},
    '{18'sd27408, -18'sd30803, 18'sd11085, -18'sd13520, 18'sd4827},
    '{18'sd32521, -18'sd37967, 18'sd13781, -18'sd12607, 18'sd4559},
    '{18'sd38573, -18'sd46647, 18'sd17093, -18'sd11668, 18'sd4304}
  };

  function automatic logic signed [MUL_A_W-1:0] sx16(input logic signed [15:0] v);
    return {{(MUL_A_W-16){v[15]}}, v};
  endfunction

  logic signed [15:0]        x_r;
  logic signed [39:0]        acc_r;
  logic [31:0]               m_r;
  logic [16:0]               g_r;
  logic                      open_r;
  hist_t                     bass_r;
  hist_t                     treb_r;

  hist_t                     cur;
  hist_t                     hist_new;
  logic [3:0]                lvl;
  logic [4:0]                lsum;
  logic [3:0]                idx;
  logic [2:0]                k;
  logic signed [17:0]        coef;
  logic signed [15:0]        xs;
  logic [16:0]               mag;
  logic signed [39:0]        prod40;
  logic signed [34:0]        psh;
  logic signed [39:0]        fsum;
  logic signed [39:0]        fsat;
  logic signed [14:0]        y;
  logic [31:0]               m_sat;
  logic [16:0]               gq;
  logic [17:0]               gsum;
  logic [16:0]               g_up;
  logic signed [MUL_P_W-1:0] xr;

  always_comb begin
    cur = ctrl.filt ? treb_r : bass_r;

    // clamp the shelf level to the table range
    lvl  = ctrl.filt ? cfg.treb_lvl : cfg.bass_lvl;
    lsum = {lvl[3], lvl} + 5'd5;
    if ($signed(lvl) < -4'sd5) begin
      idx = 4'd0;
    end else if ($signed(lvl) > 4'sd5) begin
      idx = 4'd10;
    end else begin
      idx = lsum[3:0];
    end

    case (ctrl.b_sel)
      B_C0:    k = 3'd0;
      B_C1:    k = 3'd1;
      B_C2:    k = 3'd2;
      B_C3:    k = 3'd3;
      B_C4:    k = 3'd4;
      default: k = 3'd0;
    endcase
    coef = ctrl.filt ? TREB_COEF[idx][k] : BASS_COEF[idx][k];

    xs  = x_r >>> 1;
    mag = x_r[15] ? 17'(-{x_r[15], x_r}) : {1'b0, x_r};

    case (ctrl.a_sel)
      A_M:     mul_a = {1'b0, m_r};
      A_MAG:   mul_a = {16'd0, mag};
      A_G:     mul_a = {16'd0, g_r};
      A_X:     mul_a = sx16(x_r);
      A_XS:    mul_a = sx16(xs);
      A_XH0:   mul_a = sx16(cur.xh0);
      A_XH1:   mul_a = sx16(cur.xh1);
      A_YH0:   mul_a = sx16(cur.yh0);
      A_YH1:   mul_a = sx16(cur.yh1);
      default: mul_a = '0;
    endcase

    case (ctrl.b_sel)
      B_KM:    mul_b = K_M_DECAY;
      B_KMAG:  mul_b = K_M_ATTACK;
      B_KG:    mul_b = open_r ? K_G_OPEN : K_G_CLOSED;
      B_GAIN:  mul_b = {1'b0, g_r};
      default: mul_b = coef;
    endcase

    prod40 = prod[39:0];
    psh    = prod[MUL_P_W-1:16];

    // gate: saturated magnitude and ramped gain
    m_sat = (|acc_r[39:32]) ? 32'hFFFF_FFFF : acc_r[31:0];
    gq    = prod[32:16];
    gsum  = {1'b0, gq} + G_STEP;
    g_up  = (gsum > G_UNITY) ? G_UNITY[16:0] : gsum[16:0];

    // scaled sample truncated toward zero
    xr = prod[MUL_P_W-1] ? prod + MUL_P_W'(65535) : prod;

    // shelf result: saturate, keep the dropped fraction
    fsum = acc_r - prod40;
    if (fsum > ACC_HI) begin
      fsat = ACC_HI;
    end else if (fsum < ACC_LO) begin
      fsat = ACC_LO;
    end else begin
      fsat = fsum;
    end
    y = fsat[28:14];

    hist_new.xh1 = cur.xh0;
    hist_new.xh0 = xs;
    hist_new.yh1 = cur.yh0;
    hist_new.yh0 = {y[14], y};
    hist_new.res = fsat[13:0];
  end

  assign y_out = {y, 1'b0};

  // sample and accumulator
  always_ff @(posedge clk) begin
    if (load) begin
      x_r <= x_in;
    end else if (exec) begin
      case (ctrl.act)
        ACT_X_GATE:    x_r <= xr[31:16];
        ACT_FILT_DONE: x_r <= {y, 1'b0};
        default:       x_r <= x_r;
      endcase
    end
    if (exec) begin
      case (ctrl.act)
        ACT_LOAD_SH16: acc_r <= {{5{psh[34]}}, psh};
        ACT_ADD:       acc_r <= acc_r + prod40;
        ACT_SUB:       acc_r <= acc_r - prod40;
        ACT_LOAD_RES:  acc_r <= prod40 + $signed({26'd0, cur.res});
        default:       acc_r <= acc_r;
      endcase
    end
  end

  // gate and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r    <= '0;
      g_r    <= '0;
      open_r <= 1'b0;
      bass_r <= '0;
      treb_r <= '0;
    end else if (exec) begin
      case (ctrl.act)
        ACT_GATE_UPD: begin
          m_r <= m_sat;
          g_r <= open_r ? g_up : gq;
        end
        ACT_GATE_DEC: begin
          if (open_r) begin
            if (m_r < {1'b0, cfg.close_lvl, 16'd0}) begin
              open_r <= 1'b0;
            end
          end else if (m_r > {1'b0, cfg.open_lvl, 16'd0}) begin
            open_r <= 1'b1;
          end
        end
        ACT_FILT_DONE: begin
          if (ctrl.filt) begin
            treb_r <= hist_new;
          end else begin
            bass_r <= hist_new;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/speech_gate_and_tone_chain.sv
// top level of the speech gate and tone chain
//
// one signed 16-bit sample enters on the in_ stream, one processed sample
// leaves on the out_ stream for every input transaction
// processing: optional noise gate (smoothed magnitude with hysteresis and a
// ramped gain), then a bass shelf and a treble shelf biquad with error feedback
// a microcoded sequencer steps a single shared multiplier through the work,
// one product per cycle except while the final step stalls on the output
// register; with the gate enabled the program runs the gate steps, then the
// bass and treble shelves; with the gate bypassed it skips to the bass shelf
// a new sample is accepted only once the previous one has been processed;
// in_tready is high whenever the sequencer is idle
// the result sits in an output register; a stalled receiver holds only the
// final step of the next sample until that register is taken
// reset (rst_n low, synchronous) clears the gate and filter history, restores
// register defaults and drops any pending transaction
// cfg_ writes are taken at any clock edge, meant while the block is idle
module speech_gate_and_tone_chain import sgtc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] sample_in
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] sample_out
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [14:0] cfg_wdata
);

  cfg_t                      cfg_r;
  ctrl_t                     ctrl;
  seq_stat_t                 stat;
  logic                      start;
  logic                      out_valid_r;
  logic [15:0]               out_data_r;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic signed [15:0]        y_out;

  assign in_tready = !stat.busy;
  assign start     = in_tvalid && in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gate_en   <= 1'b0;
      cfg_r.treb_lvl  <= 4'd0;
      cfg_r.bass_lvl  <= 4'd0;
      cfg_r.open_lvl  <= GATE_OPEN_RST;
      cfg_r.close_lvl <= GATE_CLOSE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GATE_ENABLE:  cfg_r.gate_en   <= cfg_wdata[0];
        REG_TREBLE_LEVEL: cfg_r.treb_lvl  <= cfg_wdata[3:0];
        REG_BASS_LEVEL:   cfg_r.bass_lvl  <= cfg_wdata[3:0];
        REG_GATE_OPEN:    cfg_r.open_lvl  <= cfg_wdata;
        REG_GATE_CLOSE:   cfg_r.close_lvl <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  sgtc_useq u_useq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .gate_en     (cfg_r.gate_en),
    .out_blocked (out_valid_r && !out_tready),
    .ctrl        (ctrl),
    .stat        (stat)
  );

  sgtc_mul u_mul (
    .clk (clk),
    .en  (stat.exec),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  sgtc_dp u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (start),
    .x_in  (in_tdata),
    .exec  (stat.exec),
    .ctrl  (ctrl),
    .cfg   (cfg_r),
    .prod  (prod),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .y_out (y_out)
  );

  // output register, loaded on the last step of the program
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.fin) begin
      out_data_r <= y_out;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
